>>> rtl/slbs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Status LED blink sequencer package
// Shared types, register indexes and color tables for the blink sequencer.
// ----------------------------------------------------------------------------
package slbs_pkg;

   localparam int COLOUR_COUNT = 7;
   localparam int COLOUR_W     = 3;
   localparam int TIME_W       = 32;
   localparam int CSR_W        = 16;
   localparam int CSR_IDX_W    = 2;

   localparam logic [COLOUR_W-1:0] COLOUR_NONE = COLOUR_W'(COLOUR_COUNT);

   // Pin levels: bit 0 red, bit 1 green, bit 2 blue; a low bit lights the pin.
   localparam logic [2:0] PINS_DARK = 3'b111;

   localparam logic [CSR_IDX_W-1:0] CSR_SCAN_PERIOD = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LIT_TIME    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_DARK_TIME   = 2'd2;

   localparam logic [CSR_W-1:0] SCAN_PERIOD_RESET = 16'd2000;
   localparam logic [CSR_W-1:0] LIT_TIME_RESET    = 16'd300;
   localparam logic [CSR_W-1:0] DARK_TIME_RESET   = 16'd200;

   typedef enum logic [1:0] {
      MODE_IDLE    = 2'd0,
      MODE_SHOWING = 2'd1,
      MODE_GAP     = 2'd2
   } mode_type;

   // Active-low pin pattern for each color index.
   function automatic logic [2:0] colour_pins(input logic [COLOUR_W-1:0] idx);
      logic [2:0] pins;
      unique case (idx)
         3'd0:    pins = 3'b110;   // red
         3'd1:    pins = 3'b101;   // green
         3'd2:    pins = 3'b011;   // blue
         3'd3:    pins = 3'b010;   // purple
         3'd4:    pins = 3'b100;   // yellow
         3'd5:    pins = 3'b001;   // cyan
         3'd6:    pins = 3'b000;   // white
         default: pins = PINS_DARK;
      endcase
      return pins;
   endfunction

   // Lowest set mask bit at or after start; COLOUR_NONE when there is none.
   function automatic logic [COLOUR_W-1:0] scan_from(
      input logic [COLOUR_COUNT-1:0] mask,
      input logic [COLOUR_W:0]       start
   );
      logic [COLOUR_W-1:0] idx;
      logic                found;
      idx   = COLOUR_NONE;
      found = 1'b0;
      for (int i = 0; i < COLOUR_COUNT; i++) begin
         if (!found && (COLOUR_W'(i) >= start) && mask[i]) begin
            idx   = COLOUR_W'(i);
            found = 1'b1;
         end
      end
      return idx;
   endfunction

endpackage

>>> rtl/status_led_blink_sequencer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Status LED blink sequencer
// Walks the active colors of a seven-color mask on an active-low RGB LED.
// ----------------------------------------------------------------------------
// Usage:
//   Each beat on the req_ channel is one update tick: a free-running 32-bit
//   timestamp and a mask of active colors. Every accepted tick yields exactly
//   one beat on the rsp_ channel with the three pin levels and the phase
//   (0 idle, 1 showing, 2 gap) after the tick.
//   The csr_ port writes the scan period (0), the lit time (1) and the
//   dark time (2); other indexes are ignored. Write only while idle.
//   The result beat is valid in the cycle after its tick is accepted. A tick
//   can be accepted every cycle while rsp_ready is high; the state update
//   and the priority scan finish in the cycle of acceptance and the result
//   lands in one output register. When the receiver stalls, the output
//   register holds its beat and req_ready drops until that beat is taken.
//   A synchronous reset restores the register defaults (2000, 300, 200),
//   puts the machine in idle with the LED dark and empties the output.
// ----------------------------------------------------------------------------
module status_led_blink_sequencer (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [slbs_pkg::TIME_W-1:0]         req_now_time,
   input  logic [slbs_pkg::COLOUR_COUNT-1:0]   req_active_mask,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic                                rsp_red_level,
   output logic                                rsp_green_level,
   output logic                                rsp_blue_level,
   output logic [1:0]                          rsp_phase,
   input  logic                                csr_write_en,
   input  logic [slbs_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [slbs_pkg::CSR_W-1:0]          csr_wdata
);
   import slbs_pkg::*;

   logic [CSR_W-1:0]    scan_period_ff;
   logic [CSR_W-1:0]    lit_time_ff;
   logic [CSR_W-1:0]    dark_time_ff;

   mode_type            mode_ff, mode_in;
   logic [TIME_W-1:0]   phase_start_ff, phase_start_in;
   logic [COLOUR_W-1:0] colour_ff, colour_in;
   logic [2:0]          pins_ff, pins_in;

   logic                rsp_valid_ff;
   logic [2:0]          rsp_pins_ff;
   mode_type            rsp_mode_ff;

   logic                accept;
   logic [TIME_W-1:0]   elapsed;
   logic [COLOUR_W-1:0] next_colour;
   logic [COLOUR_W-1:0] first_colour;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;
   assign elapsed   = req_now_time - phase_start_ff;

   assign next_colour  = scan_from(req_active_mask, {1'b0, colour_ff} + 4'd1);
   assign first_colour = scan_from(req_active_mask, '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         scan_period_ff <= SCAN_PERIOD_RESET;
         lit_time_ff    <= LIT_TIME_RESET;
         dark_time_ff   <= DARK_TIME_RESET;
      end else if (csr_write_en) begin
         unique case (csr_index)
            CSR_SCAN_PERIOD: scan_period_ff <= csr_wdata;
            CSR_LIT_TIME:    lit_time_ff    <= csr_wdata;
            CSR_DARK_TIME:   dark_time_ff   <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      mode_in        = mode_ff;
      phase_start_in = phase_start_ff;
      colour_in      = colour_ff;
      pins_in        = pins_ff;
      unique case (mode_ff)
         MODE_SHOWING: begin
            if (elapsed >= TIME_W'(lit_time_ff)) begin
               pins_in        = PINS_DARK;
               colour_in      = next_colour;
               mode_in        = (next_colour != COLOUR_NONE) ? MODE_GAP : MODE_IDLE;
               phase_start_in = req_now_time;
            end
         end
         MODE_GAP: begin
            if (elapsed >= TIME_W'(dark_time_ff)) begin
               pins_in        = colour_pins(colour_ff);
               mode_in        = MODE_SHOWING;
               phase_start_in = req_now_time;
            end
         end
         default: begin
            mode_in = MODE_IDLE;
            // An empty scan leaves the start time alone, so it retries each tick.
            if (elapsed >= TIME_W'(scan_period_ff)) begin
               colour_in = first_colour;
               if (first_colour != COLOUR_NONE) begin
                  pins_in        = colour_pins(first_colour);
                  mode_in        = MODE_SHOWING;
                  phase_start_in = req_now_time;
               end
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff        <= MODE_IDLE;
         phase_start_ff <= '0;
         colour_ff      <= '0;
         pins_ff        <= PINS_DARK;
      end else if (accept) begin
         mode_ff        <= mode_in;
         phase_start_ff <= phase_start_in;
         colour_ff      <= colour_in;
         pins_ff        <= pins_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_pins_ff <= pins_in;
         rsp_mode_ff <= mode_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_red_level   = rsp_pins_ff[0];
   assign rsp_green_level = rsp_pins_ff[1];
   assign rsp_blue_level  = rsp_pins_ff[2];
   assign rsp_phase       = rsp_mode_ff;

`ifndef SYNTHESIS
   a_showing_lit: assert property (@(posedge clock) disable iff (reset)
      mode_ff == MODE_SHOWING |-> pins_ff != PINS_DARK)
      else $error("LED dark while showing a color");

   a_gap_dark: assert property (@(posedge clock) disable iff (reset)
      mode_ff == MODE_GAP |-> pins_ff == PINS_DARK)
      else $error("LED lit during the gap");

   a_gap_colour: assert property (@(posedge clock) disable iff (reset)
      mode_ff == MODE_GAP |-> colour_ff != COLOUR_NONE)
      else $error("Gap entered without a pending color");

   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid_ff && rsp_mode_ff == mode_ff && rsp_pins_ff == pins_ff)
      else $error("Result beat does not match the updated state");
`endif

endmodule

>>> tb/sv/tb_status_led_blink_sequencer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Status LED blink sequencer testbench
// Sends update ticks with advancing, wrapping and jumping timestamps and
// random color masks through randomly stalled handshakes, and checks every
// result beat against a cycle-free model of the idle/showing/gap machine.
// ----------------------------------------------------------------------------
module tb_status_led_blink_sequencer;
   import slbs_pkg::*;

   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 2'd3;
   localparam int WATCHDOG_LIMIT  = 2000;
   localparam int RANDOM_PHASES   = 6;
   localparam int ITEMS_PER_PHASE = 100;

   typedef struct packed {
      logic     red;
      logic     green;
      logic     blue;
      mode_type phase;
   } led_beat_type;

   logic                    clock           = 1'b0;
   logic                    reset           = 1'b1;
   logic                    req_valid       = 1'b0;
   logic                    req_ready;
   logic [TIME_W-1:0]       req_now_time    = '0;
   logic [COLOUR_COUNT-1:0] req_active_mask = '0;
   logic                    rsp_valid;
   logic                    rsp_ready       = 1'b0;
   logic                    rsp_red_level;
   logic                    rsp_green_level;
   logic                    rsp_blue_level;
   logic [1:0]              rsp_phase;
   logic                    csr_write_en    = 1'b0;
   logic [CSR_IDX_W-1:0]    csr_index       = '0;
   logic [CSR_W-1:0]        csr_wdata       = '0;

   // Mirror of the sequencer registers and state.
   logic [CSR_W-1:0]    cfg_interval = SCAN_PERIOD_RESET;
   logic [CSR_W-1:0]    cfg_blink    = LIT_TIME_RESET;
   logic [CSR_W-1:0]    cfg_gap      = DARK_TIME_RESET;
   mode_type            seq_mode     = MODE_IDLE;
   logic [TIME_W-1:0]   seq_since    = '0;
   logic [COLOUR_W-1:0] seq_color    = '0;
   logic [2:0]          seq_pins     = PINS_DARK;

   led_beat_type      expected_leds[$];
   logic [TIME_W-1:0] tb_now       = '0;
   int                errors       = 0;
   int                stall_left   = 0;
   int                quiet_cycles = 0;
   bit                idle_on      = 1'b1;
   bit                run_done     = 1'b0;

   always #5 clock = ~clock;

   status_led_blink_sequencer DUT (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_now_time    (req_now_time),
      .req_active_mask (req_active_mask),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_red_level   (rsp_red_level),
      .rsp_green_level (rsp_green_level),
      .rsp_blue_level  (rsp_blue_level),
      .rsp_phase       (rsp_phase),
      .csr_write_en    (csr_write_en),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   // Secondary colors mix the primaries; the pins are active low, bit 0 red.
   function automatic logic [2:0] lit_pattern(input int idx);
      logic r, g, b;
      r = (idx == 0) || (idx == 3) || (idx == 4) || (idx == 6);
      g = (idx == 1) || (idx == 4) || (idx == 5) || (idx == 6);
      b = (idx == 2) || (idx == 3) || (idx == 5) || (idx == 6);
      return ~{b, g, r};
   endfunction

   function automatic int first_active(input int start, input logic [COLOUR_COUNT-1:0] mask);
      for (int i = start; i < COLOUR_COUNT; i++)
         if (mask[i]) return i;
      return COLOUR_COUNT;
   endfunction

   function automatic led_beat_type predict_tick(input logic [TIME_W-1:0] now,
                                                 input logic [COLOUR_COUNT-1:0] mask);
      logic [TIME_W-1:0] elapsed;
      int                hit;
      led_beat_type      beat;
      elapsed = now - seq_since;
      case (seq_mode)
         MODE_SHOWING: begin
            if (elapsed >= TIME_W'(cfg_blink)) begin
               hit       = first_active(int'(seq_color) + 1, mask);
               seq_pins  = PINS_DARK;
               seq_color = COLOUR_W'(hit);
               if (hit < COLOUR_COUNT) seq_mode = MODE_GAP;
               else seq_mode = MODE_IDLE;
               seq_since = now;
            end
         end
         MODE_GAP: begin
            // The color chosen when showing ended is lit regardless of the mask now.
            if (elapsed >= TIME_W'(cfg_gap)) begin
               seq_pins  = lit_pattern(int'(seq_color));
               seq_mode  = MODE_SHOWING;
               seq_since = now;
            end
         end
         default: begin
            seq_mode = MODE_IDLE;
            // An empty scan keeps the old start time, so it repeats every tick.
            if (elapsed >= TIME_W'(cfg_interval)) begin
               hit       = first_active(0, mask);
               seq_color = COLOUR_W'(hit);
               if (hit < COLOUR_COUNT) begin
                  seq_pins  = lit_pattern(hit);
                  seq_mode  = MODE_SHOWING;
                  seq_since = now;
               end
            end
         end
      endcase
      beat.red   = seq_pins[0];
      beat.green = seq_pins[1];
      beat.blue  = seq_pins[2];
      beat.phase = seq_mode;
      return beat;
   endfunction

   task automatic send_tick(input logic [TIME_W-1:0] now, input logic [COLOUR_COUNT-1:0] mask);
      if (idle_on && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 17)) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_now_time    <= now;
      req_active_mask <= mask;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      expected_leds.push_back(predict_tick(now, mask));
   endtask

   // Aims a tick at a given distance from the start of the current state.
   task automatic tick_after(input logic [TIME_W-1:0] offset, input logic [COLOUR_COUNT-1:0] mask);
      send_tick(seq_since + offset, mask);
   endtask

   task automatic wait_for_results();
      req_valid <= 1'b0;
      while (expected_leds.size() != 0) @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_W-1:0] value);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_wdata    <= value;
      @(posedge clock);
      csr_write_en <= 1'b0;
      @(posedge clock);
      case (idx)
         CSR_SCAN_PERIOD: cfg_interval = value;
         CSR_LIT_TIME:    cfg_blink    = value;
         CSR_DARK_TIME:   cfg_gap      = value;
         default: ;
      endcase
   endtask

   task automatic set_timing(input logic [CSR_W-1:0] interval, input logic [CSR_W-1:0] blink,
                             input logic [CSR_W-1:0] gap);
      wait_for_results();
      csr_write(CSR_SCAN_PERIOD, interval);
      csr_write(CSR_LIT_TIME, blink);
      csr_write(CSR_DARK_TIME, gap);
   endtask

   task automatic random_tick(input int span);
      int                      pick;
      logic [COLOUR_COUNT-1:0] mask;
      pick = $urandom_range(0, 19);
      if (pick == 0) tb_now = $urandom;
      else if (pick == 1) tb_now = tb_now - $urandom_range(1, span);
      else tb_now = tb_now + $urandom_range(0, span);
      case ($urandom_range(0, 7))
         0: mask = '0;
         1: mask = COLOUR_COUNT'(1) << $urandom_range(0, COLOUR_COUNT - 1);
         default: mask = COLOUR_COUNT'($urandom);
      endcase
      send_tick(tb_now, mask);
   endtask

   task automatic test_reset_defaults();
      send_tick(32'd0, 7'h7F);
      send_tick(32'd1999, 7'h7F);
      // Interval has passed but nothing is active: the machine stays idle.
      send_tick(32'd2000, 7'h00);
      send_tick(32'd2001, 7'h00);
      send_tick(32'd2002, 7'b1000001);
      send_tick(32'd2301, 7'b1000001);
      send_tick(32'd2302, 7'b1000001);
      // White comes on after the gap although its mask bit has dropped.
      send_tick(32'd2502, 7'h00);
      // No color after white, so the LED goes dark and the machine idles.
      send_tick(32'd2802, 7'h00);
      send_tick(32'd4802, 7'h7F);
   endtask

   task automatic test_zero_durations();
      set_timing(16'd0, 16'd0, 16'd0);
      // With zero times every tick moves the machine on, even at equal stamps.
      repeat (9) send_tick(32'hFFFF_FFF8, 7'b1010101);
      wait_for_results();
      // Index three maps to no register, so the zero timing must hold.
      csr_write(CSR_UNUSED, 16'h1234);
      repeat (3) send_tick(32'hFFFF_FFF8, 7'b0100000);
   endtask

   task automatic test_max_durations();
      set_timing(16'hFFFF, 16'hFFFF, 16'hFFFF);
      repeat (2) begin
         tick_after(32'd65534, 7'h7F);
         tick_after(32'd65535, 7'h7F);
      end
      send_tick(32'hFFFF_FFFF, 7'h7F);
      tick_after(32'd65535, 7'h40);
   endtask

   task automatic test_random_sequences();
      int span;
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         case (p)
            0: set_timing(16'd0, 16'd0, 16'd0);
            1: set_timing(16'hFFFF, 16'hFFFF, 16'hFFFF);
            3: set_timing(CSR_W'($urandom), CSR_W'($urandom), CSR_W'($urandom));
            default: set_timing(CSR_W'($urandom_range(0, 120)), CSR_W'($urandom_range(0, 60)),
                                CSR_W'($urandom_range(0, 60)));
         endcase
         idle_on = ($urandom_range(0, 3) != 0);
         if (p == 2) tb_now = 32'hFFFF_FFFF - $urandom_range(0, 300);
         span = 2 * int'(cfg_interval > cfg_blink ?
                         (cfg_interval > cfg_gap ? cfg_interval : cfg_gap) :
                         (cfg_blink > cfg_gap ? cfg_blink : cfg_gap)) + 1;
         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            if (p == 4 && n == ITEMS_PER_PHASE / 2) wait_for_results();
            random_tick(span);
         end
      end
   endtask

   task automatic test_back_to_back();
      set_timing(CSR_W'($urandom_range(0, 100)), CSR_W'($urandom_range(0, 40)),
                 CSR_W'($urandom_range(0, 40)));
      idle_on = 1'b0;
      repeat (ITEMS_PER_PHASE) random_tick(90);
   endtask

   task automatic check_field(input string name, input int want, input int got);
      if (want != got) begin
         errors++;
         $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
      end
   endtask

   always @(posedge clock) begin
      if (idle_on && stall_left != 0) begin
         rsp_ready  <= 1'b0;
         stall_left <= stall_left - 1;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
         rsp_ready  <= 1'b0;
         stall_left <= $urandom_range(0, 16);
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin : check_results
      led_beat_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_leds.size() == 0) begin
            errors++;
            $display("%0t: beat with nothing expected, got red %b green %b blue %b phase %0d",
                     $time, rsp_red_level, rsp_green_level, rsp_blue_level, rsp_phase);
         end else begin
            want = expected_leds.pop_front();
            check_field("red_level", want.red, rsp_red_level);
            check_field("green_level", want.green, rsp_green_level);
            check_field("blue_level", want.blue, rsp_blue_level);
            check_field("phase", want.phase, rsp_phase);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || run_done || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("[status_led_blink_sequencer] ERROR");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      test_reset_defaults();
      test_zero_durations();
      test_max_durations();
      test_random_sequences();
      test_back_to_back();
      wait_for_results();
      repeat (4) @(posedge clock);
      run_done = 1'b1;
      if (errors == 0 && expected_leds.size() == 0) begin
         $display("[status_led_blink_sequencer] OK");
      end else begin
         $display("[status_led_blink_sequencer] ERROR");
      end
      $finish;
   end

endmodule

>>> status_led_blink_sequencer.f
rtl/slbs_pkg.sv
rtl/status_led_blink_sequencer.sv
tb/sv/tb_status_led_blink_sequencer.sv
